// ===== src/rlq_pkg.sv =====
// Package for the remote link qualifier: request and response payload types,
// the qualifier state record, and the link state and diagnostic codes.
// No dependencies.
package rlq_pkg;

   // Link state codes as they appear on the response.
   localparam logic [1:0] MODE_OFFLINE    = 2'd0;
   localparam logic [1:0] MODE_QUALIFYING = 2'd1;
   localparam logic [1:0] MODE_ONLINE     = 2'd2;
   localparam logic [1:0] MODE_FAILSAFE   = 2'd3;

   // Diagnostic codes latched by the fault checks.
   localparam logic [2:0] DIAG_NONE     = 3'd0;
   localparam logic [2:0] DIAG_TIMEOUT  = 3'd1;
   localparam logic [2:0] DIAG_FAILSAFE = 3'd2;
   localparam logic [2:0] DIAG_DECODE   = 3'd3;
   localparam logic [2:0] DIAG_IMPLAUS  = 3'd4;

   // Hold time loaded at reset, in milliseconds.
   localparam logic [15:0] HOLD_TIME_RESET = 16'd200;

   // One link-status snapshot.
   typedef struct packed {
      logic        link_timeout;
      logic        receiver_failsafe;
      logic        decode_errors_over;
      logic        implausible_data;
      logic        frame_valid;
      logic [31:0] time_ms;
   } req_type;

   // One qualifier result.
   typedef struct packed {
      logic [1:0] link_state;
      logic [2:0] diag_code;
   } rsp_type;

   // Qualifier state carried from one request to the next.
   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] qualify_start;
      logic [2:0]  last_diag;
   } state_type;

endpackage

// ===== src/remote_link_qualifier_fsm_unit.sv =====
// Top level of the remote link qualifier: input register, state registers,
// response register and the hold time register. Depends on rlq_pkg and rlq_step.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   request | req_valid, req_stall, req_data      | in
//   result  | rsp_valid, rsp_stall, rsp_data      | out
//   config  | csr_write_enable, csr_write_data    | in
//
// One request per cycle is accepted while the response is not stalled; it passes
// through the input register and then the response register.
// The state update is one priority chain and one 32-bit subtract-compare.
// Reset is synchronous: state goes offline with diagnostic ok, hold time 200.
// A stalled response holds; the input register keeps accepting until it is full.
module remote_link_qualifier_fsm_unit
   import rlq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   logic        in_valid_ff, in_valid_in;
   req_type     in_data_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;
   state_type   state_ff, state_in;
   logic [15:0] hold_time_ff;
   logic        req_accept;
   logic        advance;

   // The held request moves on when the response register is free or being taken.
   assign advance     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign req_accept  = req_valid && !req_stall;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);

   // Response register empties when taken and refills on advance.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   rlq_step u_step (
      .state        (state_ff),
      .req          (in_data_ff),
      .hold_time_ms (hold_time_ff),
      .next_state   (state_in)
   );

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{mode: MODE_OFFLINE, qualify_start: 32'd0, last_diag: DIAG_NONE};
         hold_time_ff <= HOLD_TIME_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_write_enable) begin
            hold_time_ff <= csr_write_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff.link_state <= state_in.mode;
         rsp_data_ff.diag_code  <= state_in.last_diag;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A held request always reaches an empty response register next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("held request did not advance into a free response register");

   // The response shown always matches the current qualifier state.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.link_state == state_ff.mode &&
                        rsp_data_ff.diag_code == state_ff.last_diag))
      else $error("response does not match qualifier state");

   // Online is only reached and kept with a clear diagnostic.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.mode == MODE_ONLINE) |-> (state_ff.last_diag == DIAG_NONE))
      else $error("online with a latched diagnostic");

   // Failsafe always carries one of the failsafe-class diagnostics.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.mode == MODE_FAILSAFE) |->
         (state_ff.last_diag == DIAG_FAILSAFE || state_ff.last_diag == DIAG_DECODE ||
          state_ff.last_diag == DIAG_IMPLAUS))
      else $error("failsafe without a failsafe diagnostic");

   // A full pipeline under output stall holds off new requests.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("request taken while pipeline is full and stalled");

endmodule

// ===== src/rlq_step.sv =====
// Next-state logic of the remote link qualifier for one snapshot.
// Depends on rlq_pkg for the payload, state types and codes.
module rlq_step
   import rlq_pkg::*;
(
   input  state_type   state,
   input  req_type     req,
   input  logic [15:0] hold_time_ms,
   output state_type   next_state
);

   logic [31:0] elapsed;

   // Elapsed time since qualification started, modulo 2^32.
   assign elapsed = req.time_ms - state.qualify_start;

   // Fault checks in fixed priority order, then frame validity and the hold check.
   always_comb begin
      next_state = state;
      priority if (req.link_timeout) begin
         next_state.mode          = MODE_OFFLINE;
         next_state.qualify_start = req.time_ms;
         next_state.last_diag     = DIAG_TIMEOUT;
      end else if (req.receiver_failsafe) begin
         next_state.mode          = MODE_FAILSAFE;
         next_state.qualify_start = req.time_ms;
         next_state.last_diag     = DIAG_FAILSAFE;
      end else if (req.decode_errors_over) begin
         next_state.mode          = MODE_FAILSAFE;
         next_state.qualify_start = req.time_ms;
         next_state.last_diag     = DIAG_DECODE;
      end else if (req.implausible_data) begin
         next_state.mode          = MODE_FAILSAFE;
         next_state.qualify_start = req.time_ms;
         next_state.last_diag     = DIAG_IMPLAUS;
      end else if (!req.frame_valid) begin
         // An invalid frame drops the link but keeps the last diagnostic.
         next_state.mode          = MODE_OFFLINE;
         next_state.qualify_start = req.time_ms;
      end else if (state.mode == MODE_ONLINE) begin
         next_state.last_diag = DIAG_NONE;
      end else if (state.mode == MODE_QUALIFYING) begin
         if (elapsed >= {16'd0, hold_time_ms}) begin
            next_state.mode      = MODE_ONLINE;
            next_state.last_diag = DIAG_NONE;
         end
      end else begin
         // Qualification restarts now, so only a zero hold time goes online at once.
         next_state.qualify_start = req.time_ms;
         if (hold_time_ms == 16'd0) begin
            next_state.mode      = MODE_ONLINE;
            next_state.last_diag = DIAG_NONE;
         end else begin
            next_state.mode = MODE_QUALIFYING;
         end
      end
   end

endmodule
